@@ src/alist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alist_pkg: shared types for the array list engine
// Operation and status codes, the per-cell command and the scan status.
// ----------------------------------------------------------------------------
package alist_pkg;

	localparam int DATA_W = 32;
	localparam int FIDX_W = 6;
	localparam int OCNT_W = 7;
	localparam int POS_W  = 7;
	localparam int GRP_N  = 8;   // match bits examined per scan cycle

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_INSERT     = 3'd4,
		OP_ERASE      = 3'd5,
		OP_FIND       = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic ins;   // open a slot at pos and load the value
		logic del;   // close the slot at pos
		logic cmp;   // capture the key compare
	} cell_cmd_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic              found;
		logic [FIDX_W-1:0] idx;
	} scan_stat_t;

endpackage

@@ src/alist_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alist_cell: one entry of the list
// Holds one value; takes its left or right neighbour on insert or removal
// and registers the key compare for find.
// ----------------------------------------------------------------------------
module alist_cell
	import alist_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_cmd_t         cmd,
	input  logic [CNT_W-1:0]  pos,
	input  logic [CNT_W-1:0]  count,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] data,
	output logic              match
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [DATA_W-1:0] data_q;
	logic              match_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && MY_IDX == pos) begin
			data_q <= value;
		end else if (cmd.ins && MY_IDX > pos) begin
			data_q <= left;
		end else if (cmd.del && MY_IDX >= pos) begin
			data_q <= right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmd.cmp) begin
			match_q <= (data_q == value) && (MY_IDX < count);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

@@ src/alist_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alist_scan: first-match search over the cell match bits
// Walks the match vector a group at a time from the low end.
// ----------------------------------------------------------------------------
module alist_scan
	import alist_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CAPACITY-1:0] match,
	output scan_stat_t          stat
);

	localparam int NGRP  = (CAPACITY + GRP_N - 1) / GRP_N;
	localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int OFF_W = $clog2(GRP_N);
	localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(NGRP - 1);

	typedef enum logic {S_IDLE, S_RUN} scan_state_t;

	scan_state_t            state_q;
	logic [GRP_W-1:0]       grp_q;
	logic [NGRP*GRP_N-1:0]  pad;
	logic [GRP_N-1:0]       bits;
	logic [OFF_W-1:0]       off;
	logic                   hit;
	logic                   done;

	assign pad  = (NGRP*GRP_N)'(match);
	assign bits = pad[{grp_q, {OFF_W{1'b0}}} +: GRP_N];

	always_comb begin
		off = '0;
		hit = 1'b0;
		for (int i = GRP_N - 1; i >= 0; i--) begin
			if (bits[i]) begin
				off = OFF_W'(i);
				hit = 1'b1;
			end
		end
	end

	assign done = (state_q == S_RUN) && (hit || grp_q == LAST_GRP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			grp_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					grp_q <= '0;
					if (start) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (done) begin
						state_q <= S_IDLE;
					end
					grp_q <= grp_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.busy  = (state_q == S_RUN);
	assign stat.done  = done;
	assign stat.found = done && hit;
	assign stat.idx   = hit ? FIDX_W'({grp_q, off}) : '0;

endmodule

@@ src/array_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine_unit: ordered list of 32-bit values in a row of cells
// Push, pop, insert, erase and find on a list of up to CAPACITY entries.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_*      in   tuser: op[2:0]; tdata: position[6:0], value[38:7]
//  m_*      out  tdata: status[1:0], found[2], found_index[8:3], count[15:9]
//
//  Push, pop, insert and erase are registered at acceptance; moved cells shift at once.
//  Find is resolved by the match scanner (8 per cycle).
//  A request is taken while no find is scanning and the result register is
//  empty or being drained.
//  Reset clears the count, the result valid and the scanner; cell contents
//  need no clearing.
// ----------------------------------------------------------------------------
module array_list_engine_unit
	import alist_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,    // op[2:0]
	input  logic [39:0] s_tdata,    // position[6:0], value[38:7], zero[39]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata     // status[1:0], found[2], found_index[8:3], count[15:9]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]  count_q;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;

	logic              acc;
	logic [2:0]        op;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] value;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  cnt_c;
	logic              full;
	logic              empty;
	status_t           status;
	cell_cmd_t         cmd;
	logic [CNT_W-1:0]  cell_pos;
	logic [CNT_W-1:0]  count_d;
	logic [CAPACITY-1:0] match;
	logic [DATA_W-1:0] cell_data [CAPACITY];
	scan_stat_t        scan;

	assign op       = s_tuser;
	assign position = s_tdata[POS_W-1:0];
	assign value    = s_tdata[POS_W +: DATA_W];
	assign pos_c    = CMP_W'(position);
	assign cnt_c    = CMP_W'(count_q);
	assign full     = (count_q == CAP_CNT);
	assign empty    = (count_q == '0);

	assign s_tready = !scan.busy && (!m_tvalid_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		status   = ST_OK;
		cmd      = '0;
		cell_pos = '0;
		count_d  = count_q;
		unique case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					cmd.ins  = 1'b1;
					cell_pos = (op == OP_PUSH_BACK) ? count_q : '0;
					count_d  = count_q + 1'b1;
				end
			end
			OP_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else if (pos_c > cnt_c) begin
					status = ST_RANGE;
				end else begin
					cmd.ins  = 1'b1;
					cell_pos = CNT_W'(position);
					count_d  = count_q + 1'b1;
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					// pop back only drops the count; the cells keep their data
					cmd.del  = (op == OP_POP_FRONT);
					count_d  = count_q - 1'b1;
				end
			end
			OP_ERASE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (pos_c >= cnt_c) begin
					status = ST_RANGE;
				end else begin
					cmd.del  = 1'b1;
					cell_pos = CNT_W'(position);
					count_d  = count_q - 1'b1;
				end
			end
			OP_FIND: cmd.cmp = 1'b1;
			default: ;
		endcase
		if (!acc) begin
			cmd = '0;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;
		if (i == 0) begin : g_lo
			assign left = value;
		end else begin : g_lo
			assign left = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi
			assign right = cell_data[i];
		end else begin : g_hi
			assign right = cell_data[i+1];
		end
		alist_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.pos    (cell_pos),
			.count  (count_q),
			.value  (value),
			.left   (left),
			.right  (right),
			.data   (cell_data[i]),
			.match  (match[i])
		);
	end

	alist_scan #(
		.CAPACITY (CAPACITY)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cmp),
		.match  (match),
		.stat   (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_d;
			end
			if ((acc && !cmd.cmp) || scan.done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result register: finds finish from the scanner, the rest at acceptance
	always_ff @(posedge clk) begin
		if (scan.done) begin
			m_tdata_q <= {OCNT_W'(count_q), scan.idx, scan.found, ST_OK};
		end else if (acc && !cmd.cmp) begin
			m_tdata_q <= {OCNT_W'(count_d), FIDX_W'(0), 1'b0, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_find_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_FIND) |=> (scan.busy && !m_tvalid))
		else $error("find transaction did not start the scan");

	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op != OP_FIND) |=> (m_tvalid && !scan.busy))
		else $error("no result after a list update");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == ST_OK))
		else $error("match reported with a failing status");

	a_count_hold_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan.busy |=> $stable(count_q))
		else $error("count moved during a find");
`endif

endmodule
